>>> rtl/ordered_timer_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Ordered timer queue assertion macros
// Shared assertion forms for the timer queue RTL.
// ----------------------------------------------------------------------------
`ifndef ORDERED_TIMER_QUEUE_CORE_DEFINES_SVH
`define ORDERED_TIMER_QUEUE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OTQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/otq_pkg.sv
// ----------------------------------------------------------------------------
// Ordered timer queue package
// Sizes, operation and result codes, and types shared by the queue modules.
// ----------------------------------------------------------------------------
package otq_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_DEL    = 2'd1;
	localparam logic [1:0] OP_HANDLE = 2'd2;

	localparam logic [2:0] K_ADDED    = 3'd0;
	localparam logic [2:0] K_FULL     = 3'd1;
	localparam logic [2:0] K_DELETED  = 3'd2;
	localparam logic [2:0] K_NOTFOUND = 3'd3;
	localparam logic [2:0] K_EXPIRED  = 3'd4;
	localparam logic [2:0] K_NONE     = 3'd5;

	typedef struct packed {
		logic [31:0] expire;
		logic [31:0] id;
	} entry_t;

	// What the scan compares each stored entry against.
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now;
		entry_t      key;
	} scan_ctl_t;

	// Running results of one pass over the table.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] found_idx;
		logic [CNT_W-1:0] exp_cnt;
		logic             sl_any;
		logic [31:0]      sl_min;
		logic             mn_any;
		entry_t           mn;
		logic [IDX_W-1:0] mn_idx;
	} scan_res_t;

endpackage

>>> rtl/ordered_timer_queue_core.sv
// ----------------------------------------------------------------------------
// Ordered timer queue core
// Bounded timer set ordered by expiry and id, held in a memory with one write and one read port.
// ----------------------------------------------------------------------------
// Add, delete and unused ops: one table scan, then one result.
// Handle: one scan to count expired entries, then one scan per expired entry. With none
// expired a single result of kind none follows the first scan, otherwise each later scan
// yields one expired result; a result waits while the receiver is not ready.
// One item is in flight at a time; a new item is taken while a result waits.
// Reset clears all valid bits and the id counter at once; no clearing pass.
module ordered_timer_queue_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic [31:0]        now,
	input  logic [31:0]        delay_ms,
	input  logic [31:0]        key_expire,
	input  logic [31:0]        key_id,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic [31:0]        timer_id,
	output logic [31:0]        expire_time,
	output logic               last,
	output logic signed [32:0] sleep_ms
);
	import otq_pkg::*;
	`include "ordered_timer_queue_core_defines.svh"

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_TAIL, ST_DECIDE, ST_EMIT} state_t;

	state_t           state_q;
	logic             round_q;
	logic [IDX_W-1:0] addr_q;
	logic             hit_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [1:0]       op_q;
	logic [31:0]      now_q;
	logic [31:0]      e_q;
	logic [31:0]      kexp_q;
	logic [31:0]      kid_q;
	logic [31:0]      next_id_q;
	logic [CNT_W-1:0] rem_q;
	logic [CAPACITY-1:0] valid_q;
	logic [2:0]       pkind_q;
	logic [31:0]      pid_q;
	logic [31:0]      pexp_q;
	logic             plast_q;
	logic signed [32:0] sleep_q;
	logic             out_valid_q;

	logic [32:0]      sum;
	entry_t           rdata;
	scan_ctl_t        ctl;
	scan_res_t        res;
	logic             scan_clr;
	logic             full;
	logic [IDX_W-1:0] free_idx;
	logic             mem_we;
	entry_t           wdata;
	logic             base_any;
	logic [31:0]      base_min;
	logic signed [32:0] sleep_calc;
	logic             pre_decide;
	logic             emit_go;

	assign sum = {1'b0, now} + {1'b0, delay_ms};

	assign ctl.op  = op_q;
	assign ctl.now = now_q;
	assign ctl.key = (op_q == OP_ADD) ? entry_t'{expire: e_q, id: next_id_q}
	                                  : entry_t'{expire: kexp_q, id: kid_q};

	assign scan_clr = (state_q == ST_IDLE) || (state_q == ST_EMIT);

	otq_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (free_idx),
		.wdata (wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	otq_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (scan_clr),
		.hit    (hit_s1),
		.ent    (rdata),
		.idx    (idx_s1),
		.ctl    (ctl),
		.res    (res)
	);

	// Lowest free slot; the loop runs from the top so the lowest index wins.
	always_comb begin
		full     = &valid_q;
		free_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign pre_decide = (state_q == ST_DECIDE) && !round_q;
	assign mem_we     = pre_decide && (op_q == OP_ADD) && !full && !res.found;
	assign wdata      = '{expire: e_q, id: next_id_q};

	// Earliest expiry left after the operation, then the clamped sleep time.
	always_comb begin
		base_any = res.sl_any;
		base_min = res.sl_min;
		if ((op_q == OP_ADD) && !full) begin
			base_any = 1'b1;
			if (!res.sl_any || (e_q < res.sl_min)) begin
				base_min = e_q;
			end
		end
		if (!base_any) begin
			sleep_calc = -33'sd1;
		end else if (base_min > now_q) begin
			sleep_calc = $signed({1'b0, base_min - now_q});
		end else begin
			sleep_calc = '0;
		end
	end

	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= 1'b0;
			addr_q      <= '0;
			hit_s1      <= 1'b0;
			idx_s1      <= '0;
			op_q        <= '0;
			now_q       <= '0;
			e_q         <= '0;
			kexp_q      <= '0;
			kid_q       <= '0;
			next_id_q   <= '0;
			rem_q       <= '0;
			valid_q     <= '0;
			pkind_q     <= K_NONE;
			pid_q       <= '0;
			pexp_q      <= '0;
			plast_q     <= 1'b0;
			sleep_q     <= '0;
			out_valid_q <= 1'b0;
			kind        <= K_NONE;
			timer_id    <= '0;
			expire_time <= '0;
			last        <= 1'b0;
			sleep_ms    <= '0;
		end else begin
			hit_s1 <= (state_q == ST_SCAN) && valid_q[addr_q];
			idx_s1 <= addr_q;
			if (out_valid_q && out_ready && !emit_go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						now_q   <= now;
						e_q     <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
						kexp_q  <= key_expire;
						kid_q   <= key_id;
						addr_q  <= '0;
						round_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					state_q <= ST_EMIT;
					if (round_q) begin
						// The smallest key is always among the expired ones.
						pkind_q          <= K_EXPIRED;
						pid_q            <= res.mn.id;
						pexp_q           <= res.mn.expire;
						plast_q          <= (rem_q == CNT_W'(1));
						valid_q[res.mn_idx] <= 1'b0;
						rem_q            <= rem_q - CNT_W'(1);
					end else begin
						sleep_q <= sleep_calc;
						plast_q <= 1'b1;
						case (op_q)
							OP_ADD: begin
								if (full) begin
									pkind_q <= K_FULL;
									pid_q   <= '0;
									pexp_q  <= '0;
								end else begin
									pkind_q   <= K_ADDED;
									pid_q     <= next_id_q;
									pexp_q    <= e_q;
									next_id_q <= next_id_q + 32'd1;
									if (!res.found) begin
										valid_q[free_idx] <= 1'b1;
									end
								end
							end
							OP_DEL: begin
								pid_q  <= kid_q;
								pexp_q <= kexp_q;
								if (res.found) begin
									pkind_q <= K_DELETED;
									valid_q[res.found_idx] <= 1'b0;
								end else begin
									pkind_q <= K_NOTFOUND;
								end
							end
							OP_HANDLE: begin
								pkind_q <= K_NONE;
								pid_q   <= '0;
								pexp_q  <= '0;
								if (res.exp_cnt != '0) begin
									rem_q   <= res.exp_cnt;
									round_q <= 1'b1;
									addr_q  <= '0;
									state_q <= ST_SCAN;
								end
							end
							default: begin
								pkind_q <= K_NONE;
								pid_q   <= '0;
								pexp_q  <= '0;
							end
						endcase
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						out_valid_q <= 1'b1;
						kind        <= pkind_q;
						timer_id    <= pid_q;
						expire_time <= pexp_q;
						last        <= plast_q;
						sleep_ms    <= sleep_q;
						if (round_q && (rem_q != '0)) begin
							addr_q  <= '0;
							state_q <= ST_SCAN;
						end else begin
							round_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`OTQ_ASSERT_NOW(a_round_min_expired, (state_q == ST_DECIDE) && round_q,
		res.mn_any && (res.mn.expire <= now_q), "expiry round found no expired entry")
	`OTQ_ASSERT_NOW(a_full_no_write, pre_decide && (op_q == OP_ADD) && full, !mem_we,
		"write into a full table")
	`OTQ_ASSERT_NEXT(a_id_step, 1'b1,
		(next_id_q == $past(next_id_q)) || (next_id_q == $past(next_id_q) + 32'd1),
		"id counter jumped")
	`OTQ_ASSERT_NOW(a_single_last, out_valid_q && (kind != K_EXPIRED), last,
		"single result without last marker")

endmodule

>>> rtl/otq_mem.sv
// ----------------------------------------------------------------------------
// Timer entry memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module otq_mem (
	input  logic                  clk,
	input  logic                  we,
	input  logic [otq_pkg::IDX_W-1:0] waddr,
	input  otq_pkg::entry_t       wdata,
	input  logic [otq_pkg::IDX_W-1:0] raddr,
	output otq_pkg::entry_t       rdata
);
	import otq_pkg::*;

	entry_t mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/otq_scan.sv
// ----------------------------------------------------------------------------
// Timer table scan accumulator
// Folds one entry per cycle into key match, expired count and minimums.
// ----------------------------------------------------------------------------
module otq_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  logic                      hit,
	input  otq_pkg::entry_t           ent,
	input  logic [otq_pkg::IDX_W-1:0] idx,
	input  otq_pkg::scan_ctl_t        ctl,
	output otq_pkg::scan_res_t        res
);
	import otq_pkg::*;

	logic match;
	logic expired;
	logic sl_incl;

	assign match   = (ent.expire == ctl.key.expire) && (ent.id == ctl.key.id);
	assign expired = ent.expire <= ctl.now;
	// A deleted entry and every expired entry of a handle pass are gone
	// once the operation completes, so they do not set the sleep time.
	assign sl_incl = !(((ctl.op == OP_DEL) && match) || ((ctl.op == OP_HANDLE) && expired));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res <= '0;
		end else if (clr) begin
			res <= '0;
		end else if (hit) begin
			if (match) begin
				res.found     <= 1'b1;
				res.found_idx <= idx;
			end
			if (expired) begin
				res.exp_cnt <= res.exp_cnt + CNT_W'(1);
			end
			if (sl_incl && (!res.sl_any || (ent.expire < res.sl_min))) begin
				res.sl_any <= 1'b1;
				res.sl_min <= ent.expire;
			end
			if (!res.mn_any || (ent < res.mn)) begin
				res.mn_any <= 1'b1;
				res.mn     <= ent;
				res.mn_idx <= idx;
			end
		end
	end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Ordered timer queue testbench
// Drives add, delete, handle and unused-op items through the core, predicts every
// result beat from a behavioral copy of the timer set, and compares fields.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import otq_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        timer_id;
		logic [31:0]        expire_time;
		logic               last;
		logic signed [32:0] sleep_ms;
	} timer_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         op = '0;
	logic [31:0]        now = '0;
	logic [31:0]        delay_ms = '0;
	logic [31:0]        key_expire = '0;
	logic [31:0]        key_id = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         kind;
	logic [31:0]        timer_id;
	logic [31:0]        expire_time;
	logic               last;
	logic signed [32:0] sleep_ms;

	ordered_timer_queue_core DUT (.*);

	always #4 clk = ~clk;

	// Shadow copy of the timer set.
	logic [31:0] shadow_expire [CAPACITY];
	logic [31:0] shadow_id [CAPACITY];
	logic        shadow_valid [CAPACITY];
	logic [31:0] shadow_next_id;
	timer_beat_t pending_beats [$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  recv_hold = 1'b0;
	int  mismatches = 0;
	int  quiet_cycles = 0;

	function automatic bit key_before(logic [31:0] ea, logic [31:0] ia,
			logic [31:0] eb, logic [31:0] ib);
		if (ea != eb) return ea < eb;
		return ia < ib;
	endfunction

	function automatic int earliest_slot();
		int best;
		best = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (shadow_valid[i] && (best < 0 || key_before(shadow_expire[i],
					shadow_id[i], shadow_expire[best], shadow_id[best])))
				best = i;
		return best;
	endfunction

	function automatic int slot_of(logic [31:0] e, logic [31:0] id);
		for (int i = 0; i < CAPACITY; i++)
			if (shadow_valid[i] && shadow_expire[i] == e && shadow_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void predict_timer_beats(logic [1:0] o, logic [31:0] t,
			logic [31:0] dly, logic [31:0] ke, logic [31:0] ki);
		timer_beat_t batch [$];
		timer_beat_t b;
		logic [32:0] sum;
		logic [31:0] e;
		logic signed [32:0] sl;
		int slot;
		int m;
		b = '0;
		b.last = 1'b1;
		case (o)
			OP_ADD: begin
				sum = {1'b0, t} + {1'b0, dly};
				e = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				slot = -1;
				for (int i = CAPACITY - 1; i >= 0; i--)
					if (!shadow_valid[i]) slot = i;
				if (slot < 0) begin
					b.kind = K_FULL;
				end else begin
					b.kind = K_ADDED;
					b.timer_id = shadow_next_id;
					b.expire_time = e;
					if (slot_of(e, shadow_next_id) < 0) begin
						shadow_expire[slot] = e;
						shadow_id[slot] = shadow_next_id;
						shadow_valid[slot] = 1'b1;
					end
					shadow_next_id++;
				end
				batch.push_back(b);
			end
			OP_DEL: begin
				slot = slot_of(ke, ki);
				b.kind = (slot >= 0) ? K_DELETED : K_NOTFOUND;
				b.timer_id = ki;
				b.expire_time = ke;
				if (slot >= 0) shadow_valid[slot] = 1'b0;
				batch.push_back(b);
			end
			OP_HANDLE: begin
				while (batch.size() < CAPACITY) begin
					m = earliest_slot();
					if (m < 0 || shadow_expire[m] > t) break;
					b.kind = K_EXPIRED;
					b.timer_id = shadow_id[m];
					b.expire_time = shadow_expire[m];
					b.last = 1'b0;
					shadow_valid[m] = 1'b0;
					batch.push_back(b);
				end
				if (batch.size() == 0) begin
					b = '0;
					b.kind = K_NONE;
					b.last = 1'b1;
					batch.push_back(b);
				end else begin
					batch[batch.size() - 1].last = 1'b1;
				end
			end
			default: begin
				b.kind = K_NONE;
				batch.push_back(b);
			end
		endcase
		m = earliest_slot();
		if (m < 0) sl = -33'sd1;
		else if (shadow_expire[m] <= t) sl = '0;
		else sl = $signed({1'b0, shadow_expire[m] - t});
		foreach (batch[i]) begin
			batch[i].sleep_ms = sl;
			pending_beats.push_back(batch[i]);
		end
	endfunction

	// Each beat is driven on a later falling edge than the one that dropped valid.
	task automatic send_item(logic [1:0] o, logic [31:0] t, logic [31:0] dly,
			logic [31:0] ke, logic [31:0] ki);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		op <= o;
		now <= t;
		delay_ms <= dly;
		key_expire <= ke;
		key_id <= ki;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_timer_beats(o, t, dly, ke, ki);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (CAPACITY + 8) @(negedge clk);
	endtask

	// Receiver readiness is redrawn every falling edge.
	always @(negedge clk)
		out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat kind=%0d id=%h", $realtime, kind, timer_id);
				mismatches++;
			end else begin
				timer_beat_t exp_b;
				exp_b = pending_beats.pop_front();
				if (exp_b.kind !== kind) begin
					$display("%0t: kind expected %0d actual %0d", $realtime, exp_b.kind, kind);
					mismatches++;
				end
				if (exp_b.timer_id !== timer_id) begin
					$display("%0t: timer_id expected %h actual %h", $realtime,
						exp_b.timer_id, timer_id);
					mismatches++;
				end
				if (exp_b.expire_time !== expire_time) begin
					$display("%0t: expire_time expected %h actual %h", $realtime,
						exp_b.expire_time, expire_time);
					mismatches++;
				end
				if (exp_b.last !== last) begin
					$display("%0t: last expected %0d actual %0d", $realtime, exp_b.last, last);
					mismatches++;
				end
				if (exp_b.sleep_ms !== sleep_ms) begin
					$display("%0t: sleep_ms expected %0d actual %0d", $realtime,
						exp_b.sleep_ms, sleep_ms);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(OP_HANDLE, 32'd0, '0, '0, '0);
		send_item(OP_DEL, 32'd5, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
		send_item(OP_ADD, 32'd100, 32'd0, '0, '0);
		send_item(OP_ADD, 32'd100, 32'd50, '0, '0);
		send_item(OP_ADD, 32'd100, 32'd50, '0, '0);
		send_item(OP_ADD, 32'h8000_0000, 32'h7FFF_FFFF, '0, '0);
		send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_DEL, 32'd100, '0, 32'd150, 32'd2);
		send_item(OP_DEL, 32'd100, '0, 32'd150, 32'd2);
		send_item(OP_HANDLE, 32'd99, '0, '0, '0);
		send_item(OP_HANDLE, 32'd150, '0, '0, '0);
		send_item(OP_HANDLE, 32'hFFFF_FFFF, '0, '0, '0);
		drain_results();
	endtask

	// Fill the table past capacity; the long receiver hold makes input stall.
	task automatic test_full_table();
		fork
			begin
				recv_hold = 1'b1;
				repeat (600) @(negedge clk);
				recv_hold = 1'b0;
			end
			for (int i = 0; i < CAPACITY + 2; i++)
				send_item(OP_ADD, 32'd1000, $urandom_range(7), '0, '0);
		join
		send_item(OP_HANDLE, 32'd1007, '0, '0, '0);
		drain_results();
	endtask

	task automatic test_random(int count);
		logic [31:0] base;
		int pick;
		int s;
		base = $urandom;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			base += $urandom_range(20);
			if (pick < 50) begin
				send_item(OP_ADD, base,
					($urandom_range(9) == 0) ? $urandom : $urandom_range(60), '0, '0);
			end else if (pick < 70) begin
				s = $urandom_range(CAPACITY - 1);
				if (shadow_valid[s] && $urandom_range(3) != 0)
					send_item(OP_DEL, base, $urandom, shadow_expire[s], shadow_id[s]);
				else
					send_item(OP_DEL, base, $urandom, $urandom, $urandom);
			end else if (pick < 95) begin
				send_item(OP_HANDLE, base, $urandom, $urandom, $urandom);
			end else begin
				send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
			end
		end
		send_item(OP_HANDLE, 32'hFFFF_FFFF, '0, '0, '0);
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < CAPACITY; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_expire[i] = '0;
			shadow_id[i] = '0;
		end
		shadow_next_id = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_full_table();
		send_idle_pct = 16;
		recv_idle_pct = 77;
		test_random(45);
		send_idle_pct = 77;
		recv_idle_pct = 16;
		test_random(45);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(45);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
